// ----- rtl/rps_pkg.sv -----
// rps_pkg: shared types and constants of the rtp packet serializer
// used by rps_ctrl, rps_dp and rtp_packet_serializer; no dependencies
package rps_pkg;

    // item kinds on the input tuser
    localparam logic [1:0] OP_HDR = 2'd0;
    localparam logic [1:0] OP_EXT = 2'd1;
    localparam logic [1:0] OP_PAY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_STREAM_SSRC = 2'd0;
    localparam logic [1:0] CFG_PAYLOAD_TYPE = 2'd1;
    localparam logic [1:0] CFG_RETX_SSRC = 2'd2;
    localparam logic [1:0] CFG_RETX_PT = 2'd3;

    // saturation limits of the declared lengths
    localparam int MAX_PAD = 63;
    localparam int MAX_EXT_BYTES = 1023;

    // header buffer: 12 fixed bytes plus extension header or original sequence
    localparam int HDR_BYTES = 16;
    localparam int HDR_CNT_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXT,
        ST_PAY,
        ST_HDR,
        ST_FILL,
        ST_OSEQ,
        ST_PAD
    } t_state;

    typedef enum logic [2:0] {
        SEL_DATA,
        SEL_HDR,
        SEL_ZERO,
        SEL_OSEQ,
        SEL_PADCNT
    } t_sel;

    typedef struct packed {
        logic hdr_load;
        logic hdr_shift;
        logic mod4_inc;
        logic cnt_load_pad;
        logic cnt_load_oseq;
        logic cnt_dec;
        logic out_load;
        t_sel out_sel;
        logic out_last;
        logic out_run_end;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic hdr_last;
        logic ext_on;
        logic retx_mode;
        logic mod4_wrap;
        logic pad_zero;
        logic cnt_one;
    } t_dp_stat;

endpackage

// ----- rtl/rps_ctrl.sv -----
// rps_ctrl: packet phase state machine of the rtp packet serializer
// depends on rps_pkg; drives rps_dp through t_dp_cmd and reads t_dp_stat
module rps_ctrl
    import rps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    input  logic       i_final,
    output logic       o_in_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    // items are taken only in a phase state with room at the output
    assign o_in_ready = i_stat.out_free &&
                        (r_state == ST_IDLE || r_state == ST_EXT || r_state == ST_PAY);
    assign in_acc = i_in_valid && o_in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_EXT, ST_PAY: begin
                if (in_acc) begin
                    if (i_op == OP_HDR) begin
                        n_state = ST_HDR;
                    end else if (i_op == OP_EXT && r_state == ST_EXT && i_final) begin
                        if (!i_stat.mod4_wrap) n_state = ST_FILL;
                        else if (i_stat.retx_mode) n_state = ST_OSEQ;
                        else n_state = ST_PAY;
                    end else if (i_op == OP_PAY && r_state == ST_PAY && i_final) begin
                        n_state = i_stat.pad_zero ? ST_IDLE : ST_PAD;
                    end
                end
            end
            ST_HDR: begin
                if (i_stat.out_free && i_stat.hdr_last)
                    n_state = i_stat.ext_on ? ST_EXT : ST_PAY;
            end
            ST_FILL: begin
                if (i_stat.out_free && i_stat.mod4_wrap)
                    n_state = i_stat.retx_mode ? ST_OSEQ : ST_PAY;
            end
            ST_OSEQ: begin
                if (i_stat.out_free && i_stat.cnt_one) n_state = ST_PAY;
            end
            ST_PAD: begin
                if (i_stat.out_free && i_stat.cnt_one) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd = '0;
        o_cmd.out_sel = SEL_DATA;
        case (r_state)
            ST_IDLE, ST_EXT, ST_PAY: begin
                if (in_acc) begin
                    if (i_op == OP_HDR) begin
                        o_cmd.hdr_load = 1'b1;
                    end else if (i_op == OP_EXT && r_state == ST_EXT) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.mod4_inc = 1'b1;
                        if (!i_final) begin
                            o_cmd.out_run_end = 1'b1;
                        end else if (i_stat.mod4_wrap) begin
                            o_cmd.cnt_load_oseq = i_stat.retx_mode;
                            o_cmd.out_run_end = !i_stat.retx_mode;
                        end
                    end else if (i_op == OP_PAY && r_state == ST_PAY) begin
                        o_cmd.out_load = 1'b1;
                        if (!i_final) begin
                            o_cmd.out_run_end = 1'b1;
                        end else if (i_stat.pad_zero) begin
                            o_cmd.out_last = 1'b1;
                            o_cmd.out_run_end = 1'b1;
                        end else begin
                            o_cmd.cnt_load_pad = 1'b1;
                        end
                    end
                end
            end
            ST_HDR: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel = SEL_HDR;
                    o_cmd.hdr_shift = 1'b1;
                    o_cmd.out_run_end = i_stat.hdr_last;
                end
            end
            ST_FILL: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel = SEL_ZERO;
                    o_cmd.mod4_inc = 1'b1;
                    if (i_stat.mod4_wrap) begin
                        o_cmd.cnt_load_oseq = i_stat.retx_mode;
                        o_cmd.out_run_end = !i_stat.retx_mode;
                    end
                end
            end
            ST_OSEQ: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel = SEL_OSEQ;
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.out_run_end = i_stat.cnt_one;
                end
            end
            ST_PAD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel = i_stat.cnt_one ? SEL_PADCNT : SEL_ZERO;
                    o_cmd.cnt_dec = 1'b1;
                    o_cmd.out_last = i_stat.cnt_one;
                    o_cmd.out_run_end = i_stat.cnt_one;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/rps_dp.sv -----
// rps_dp: datapath of the rtp packet serializer: config registers, header
// buffer, packet counters and output register; depends on rps_pkg
module rps_dp
    import rps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_marker,
    input  logic        i_retransmit,
    input  logic [15:0] i_seq_number,
    input  logic [15:0] i_retx_seq_number,
    input  logic [31:0] i_time_stamp,
    input  logic [5:0]  i_pad_count,
    input  logic [15:0] i_ext_profile,
    input  logic [9:0]  i_ext_byte_count,
    input  logic [7:0]  i_data_byte,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic        o_out_run_end
);

    localparam logic [16:0] MAX_EXT17 = 17'(MAX_EXT_BYTES);
    localparam logic [5:0]  MAX_PAD6 = 6'(MAX_PAD);

    logic [31:0] r_stream_ssrc;
    logic [6:0]  r_payload_type;
    logic [31:0] r_retx_ssrc;
    logic [6:0]  r_retx_pt;

    logic [HDR_BYTES*8-1:0] r_hdr_sh;
    logic [HDR_CNT_W-1:0]   r_hdr_left;
    logic                   r_ext_on;
    logic                   r_retx_mode;
    logic [15:0]            r_orig_seq;
    logic [5:0]             r_pad_left;
    logic [1:0]             r_mod4;
    logic [5:0]             r_cnt;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_run_end;

    logic [16:0] ext_sat;
    logic [17:0] ext_round;
    logic [15:0] ext_words;
    logic [5:0]  pad_sat;
    logic [15:0] hdr_word;
    logic [6:0]  pt_sel;
    logic [31:0] ssrc_sel;
    logic [15:0] seq_sel;
    logic [31:0] tail;
    logic [HDR_BYTES*8-1:0] hdr_img;
    logic [HDR_CNT_W-1:0]   hdr_len;
    logic [1:0]  mod4_next;
    logic [7:0]  out_mux;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_ssrc  <= '0;
            r_payload_type <= '0;
            r_retx_ssrc    <= '0;
            r_retx_pt      <= 7'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STREAM_SSRC:  r_stream_ssrc <= i_cfg_data;
                CFG_PAYLOAD_TYPE: r_payload_type <= i_cfg_data[6:0];
                CFG_RETX_SSRC:    r_retx_ssrc <= i_cfg_data;
                CFG_RETX_PT:      r_retx_pt <= i_cfg_data[6:0];
                default:          r_retx_pt <= r_retx_pt;
            endcase
        end
    end

    // header image from the header item fields
    always_comb begin
        ext_sat   = ({7'd0, i_ext_byte_count} > MAX_EXT17) ? MAX_EXT17
                                                           : {7'd0, i_ext_byte_count};
        ext_round = {1'b0, ext_sat} + 18'd3;
        ext_words = ext_round[17:2];
        pad_sat   = (i_pad_count > MAX_PAD6) ? MAX_PAD6 : i_pad_count;
        pt_sel    = i_retransmit ? r_retx_pt : r_payload_type;
        ssrc_sel  = i_retransmit ? r_retx_ssrc : r_stream_ssrc;
        seq_sel   = i_retransmit ? i_retx_seq_number : i_seq_number;
        hdr_word  = {2'b10, (pad_sat != 6'd0), (ext_sat != 17'd0), 4'd0, i_marker, pt_sel};
        if (ext_sat != 17'd0) begin
            tail    = {ext_words[7:0], ext_words[15:8], i_ext_profile[7:0],
                       i_ext_profile[15:8]};
            hdr_len = HDR_CNT_W'(HDR_BYTES);
        end else if (i_retransmit) begin
            tail    = {16'd0, i_seq_number[7:0], i_seq_number[15:8]};
            hdr_len = HDR_CNT_W'(HDR_BYTES - 2);
        end else begin
            tail    = '0;
            hdr_len = HDR_CNT_W'(HDR_BYTES - 4);
        end
        // byte 0 goes out first and sits in the lowest bits
        hdr_img = {tail,
                   ssrc_sel[7:0], ssrc_sel[15:8], ssrc_sel[23:16], ssrc_sel[31:24],
                   i_time_stamp[7:0], i_time_stamp[15:8], i_time_stamp[23:16],
                   i_time_stamp[31:24],
                   seq_sel[7:0], seq_sel[15:8], hdr_word[7:0], hdr_word[15:8]};
    end

    // header buffer and per-packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_left  <= '0;
            r_ext_on    <= 1'b0;
            r_retx_mode <= 1'b0;
            r_orig_seq  <= '0;
            r_pad_left  <= '0;
            r_mod4      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.hdr_load) begin
                r_hdr_left  <= hdr_len;
                r_ext_on    <= (ext_sat != 17'd0);
                r_retx_mode <= i_retransmit;
                r_orig_seq  <= i_seq_number;
                r_pad_left  <= pad_sat;
                r_mod4      <= '0;
            end else begin
                if (i_cmd.hdr_shift) r_hdr_left <= r_hdr_left - 1'b1;
                if (i_cmd.mod4_inc) r_mod4 <= mod4_next;
            end
            if (i_cmd.cnt_load_pad) r_cnt <= r_pad_left;
            else if (i_cmd.cnt_load_oseq) r_cnt <= 6'd2;
            else if (i_cmd.cnt_dec) r_cnt <= r_cnt - 1'b1;
        end
    end

    // header bytes shift toward the low end
    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_load) r_hdr_sh <= hdr_img;
        else if (i_cmd.hdr_shift) r_hdr_sh <= {8'd0, r_hdr_sh[HDR_BYTES*8-1:8]};
    end

    assign mod4_next = r_mod4 + 2'd1;

    // output byte select
    always_comb begin
        case (i_cmd.out_sel)
            SEL_DATA:   out_mux = i_data_byte;
            SEL_HDR:    out_mux = r_hdr_sh[7:0];
            SEL_ZERO:   out_mux = 8'd0;
            SEL_OSEQ:   out_mux = r_cnt[0] ? r_orig_seq[7:0] : r_orig_seq[15:8];
            SEL_PADCNT: out_mux = {2'd0, r_pad_left};
            default:    out_mux = 8'd0;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte    <= out_mux;
            r_out_last    <= i_cmd.out_last;
            r_out_run_end <= i_cmd.out_run_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_last    = r_out_last;
    assign o_out_run_end = r_out_run_end;

    // status toward the controller
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.hdr_last  = (r_hdr_left == HDR_CNT_W'(1));
    assign o_stat.ext_on    = r_ext_on;
    assign o_stat.retx_mode = r_retx_mode;
    assign o_stat.mod4_wrap = (mod4_next == 2'd0);
    assign o_stat.pad_zero  = (r_pad_left == 6'd0);
    assign o_stat.cnt_one   = (r_cnt == 6'd1);

endmodule

// ----- rtl/rtp_packet_serializer.sv -----
// rtp_packet_serializer: top level, turns header, extension and payload items
// into an rtp byte stream; depends on rps_pkg, rps_ctrl and rps_dp
//
// usage:
//   slave channel takes items; tuser is the kind (header, extension byte,
//   payload byte), tlast marks the last extension or payload byte
//   master channel gives one packet byte per item; tlast ends the packet,
//   tuser marks the last byte caused by one input item
//   config channel writes ssrc and payload type registers; always ready
// timing:
//   a header item is taken, then its 12 to 16 header bytes leave one a cycle
//   while the master is ready; the input is held off for that run
//   extension and payload bytes pass at one byte per cycle while tready is high,
//   through the output register; closing runs (extension zero fill, original
//   sequence, padding of up to 63 bytes) go out with the input held off
//   the single output register sets the rate: one byte per cycle when unstalled
// reset: synchronous, active low; phase idle, registers at reset values
// stall: a low master tready holds the output byte and the input tready
module rtp_packet_serializer
    import rps_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // slave items
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: marker, retransmit, seq_number, retx_seq_number, time_stamp,
    //        pad_count, ext_profile, ext_byte_count, data_byte, zero fill
    input  logic [111:0] i_s_tdata,
    // tuser: op
    input  logic [1:0]   i_s_tuser,
    // tlast: final_flag
    input  logic         i_s_tlast,
    // master items
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: out_byte
    output logic [7:0]   o_m_tdata,
    // tuser: run_end
    output logic         o_m_tuser,
    // tlast: packet_end
    output logic         o_m_tlast
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    // phase controller
    rps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_final    (i_s_tlast),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    rps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_marker          (i_s_tdata[0]),
        .i_retransmit      (i_s_tdata[1]),
        .i_seq_number      (i_s_tdata[17:2]),
        .i_retx_seq_number (i_s_tdata[33:18]),
        .i_time_stamp      (i_s_tdata[65:34]),
        .i_pad_count       (i_s_tdata[71:66]),
        .i_ext_profile     (i_s_tdata[87:72]),
        .i_ext_byte_count  (i_s_tdata[97:88]),
        .i_data_byte       (i_s_tdata[105:98]),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (i_m_tready),
        .o_out_valid       (o_m_tvalid),
        .o_out_byte        (o_m_tdata),
        .o_out_last        (o_m_tlast),
        .o_out_run_end     (o_m_tuser)
    );

endmodule
